>>> rtl/fdtd_pkg.sv
`default_nettype none
package fdtd_pkg;

  localparam int NGRID = 9;
  localparam int DW    = 32;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_UPD_H = 2'd2;
  localparam logic [1:0] MODE_UPD_E = 2'd3;

  localparam logic [3:0] G_EZ   = 4'd0;
  localparam logic [3:0] G_HX   = 4'd1;
  localparam logic [3:0] G_HY   = 4'd2;
  localparam logic [3:0] G_CEZE = 4'd3;
  localparam logic [3:0] G_CEZH = 4'd4;
  localparam logic [3:0] G_CHXH = 4'd5;
  localparam logic [3:0] G_CHXE = 4'd6;
  localparam logic [3:0] G_CHYH = 4'd7;
  localparam logic [3:0] G_CHYE = 4'd8;

  localparam logic [1:0] CFG_ONE_D  = 2'd0;
  localparam logic [1:0] CFG_SIZE_X = 2'd1;
  localparam logic [1:0] CFG_SIZE_Y = 2'd2;

  typedef enum logic [1:0] {P_HX, P_HY, P_E} pass_t;

  typedef struct packed {
    logic  capture;
    logic  use_cell;
    logic  cell_write;
    logic  rd_load;
    logic  diff_load;
    logic  mul_load;
    logic  cell_we;
    logic  out_load;
    logic  out_from_read;
    logic  out_err;
    logic  one_d;
    pass_t kind;
  } fdtd_cmd_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] mode;
  } fdtd_stat_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qtrunc(input logic signed [63:0] p);
    logic signed [31:0] r;
    if ((&p[63:47]) || !(|p[63:47])) r = p[47:16];
    else r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fdtd_ram.sv
`default_nettype none
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a_r,
  output logic      [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> rtl/fdtd_datapath.sv
`default_nettype none
module fdtd_datapath #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int CW    = 11
) (
  input  wire logic                clk,
  input  wire fdtd_pkg::fdtd_cmd_t cmd,
  input  wire logic [CW-1:0]       m,
  input  wire logic [CW-1:0]       n,
  input  wire logic [1:0]          in_mode,
  input  wire logic [5:0]          in_cell_x,
  input  wire logic [5:0]          in_cell_y,
  input  wire logic [3:0]          in_grid_select,
  input  wire logic signed [31:0]  in_write_value,
  output fdtd_pkg::fdtd_stat_t     stat,
  output logic signed [31:0]       out_read_value,
  output logic                     out_status
);
  import fdtd_pkg::*;

  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int AW = XW + YW;

  logic [1:0]         mode_r;
  logic [5:0]         x_r;
  logic [5:0]         y_r;
  logic [3:0]         g_r;
  logic signed [31:0] wv_r;
  logic signed [31:0] rd_r;
  logic signed [31:0] self_r, k1_r, k2_r, d_r;
  logic signed [63:0] p1_r, p2_r;
  logic signed [31:0] out_read_value_r;
  logic               out_status_r;

  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b [NGRID];
  logic [CW-1:0]      mp, mm, np, nm;
  logic [NGRID-1:0]   we;
  logic [DW-1:0]      wdata;
  logic [DW-1:0]      qa [NGRID];
  logic [DW-1:0]      qb [NGRID];
  logic signed [31:0] self_c, k1_c, k2_c, d_c, dy, dx, q1, q2, res;
  logic [3:0]         tgt;

  always_comb begin
    mp = m + 1'b1;
    mm = m - 1'b1;
    np = n + 1'b1;
    nm = n - 1'b1;
    addr_a = cmd.use_cell ? {XW'(x_r), YW'(y_r)} : {m[XW-1:0], n[YW-1:0]};
    for (int i = 0; i < NGRID; i++) begin
      addr_b[i] = addr_a;
    end
    addr_b[G_EZ] = (cmd.kind == P_HX) ? {m[XW-1:0], np[YW-1:0]} : {mp[XW-1:0], n[YW-1:0]};
    addr_b[G_HX] = {m[XW-1:0], nm[YW-1:0]};
    addr_b[G_HY] = {mm[XW-1:0], n[YW-1:0]};
  end

  always_comb begin
    case (cmd.kind)
      P_HX:    tgt = G_HX;
      P_HY:    tgt = G_HY;
      default: tgt = G_EZ;
    endcase
    for (int i = 0; i < NGRID; i++) begin
      we[i] = (cmd.cell_write && g_r == 4'(i)) || (cmd.cell_we && tgt == 4'(i));
    end
    q1 = qtrunc(p1_r);
    q2 = qtrunc(p2_r);
    res = (cmd.kind == P_HX) ? qsub(q1, q2) : qadd(q1, q2);
    wdata = cmd.cell_write ? wv_r : res;
  end

  for (genvar gi = 0; gi < NGRID; gi++) begin : g_ram
    fdtd_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
      .clk       (clk),
      .we        (we[gi]),
      .waddr     (addr_a),
      .wdata     (wdata),
      .raddr_a   (addr_a),
      .raddr_b   (addr_b[gi]),
      .rdata_a_r (qa[gi]),
      .rdata_b_r (qb[gi])
    );
  end

  always_comb begin
    dy = qsub(qa[G_HY], qb[G_HY]);
    dx = qsub(qa[G_HX], qb[G_HX]);
    case (cmd.kind)
      P_HX: begin
        self_c = qa[G_HX];
        k1_c   = qa[G_CHXH];
        k2_c   = qa[G_CHXE];
        d_c    = qsub(qb[G_EZ], qa[G_EZ]);
      end
      P_HY: begin
        self_c = qa[G_HY];
        k1_c   = qa[G_CHYH];
        k2_c   = qa[G_CHYE];
        d_c    = qsub(qb[G_EZ], qa[G_EZ]);
      end
      default: begin
        self_c = qa[G_EZ];
        k1_c   = qa[G_CEZE];
        k2_c   = qa[G_CEZH];
        d_c    = cmd.one_d ? dy : qsub(dy, dx);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      x_r    <= in_cell_x;
      y_r    <= in_cell_y;
      g_r    <= in_grid_select;
      wv_r   <= in_write_value;
    end
    if (cmd.rd_load) begin
      rd_r <= (g_r <= G_CHYE) ? qa[g_r] : '0;
    end
    if (cmd.diff_load) begin
      self_r <= self_c;
      k1_r   <= k1_c;
      k2_r   <= k2_c;
      d_r    <= d_c;
    end
    if (cmd.mul_load) begin
      p1_r <= k1_r * self_r;
      p2_r <= k2_r * d_r;
    end
    if (cmd.out_load) begin
      out_read_value_r <= cmd.out_from_read ? rd_r : '0;
      out_status_r     <= cmd.out_err;
    end
  end

  assign stat.mode = mode_r;
  assign stat.bad  = (int'(x_r) >= MAX_X) || (int'(y_r) >= MAX_Y) || (g_r > G_CHYE);
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

>>> rtl/fdtd_ctrl.sv
`default_nettype none
module fdtd_ctrl #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int CW    = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 one_d,
  input  wire logic [6:0]           size_x,
  input  wire logic [6:0]           size_y,
  input  wire fdtd_pkg::fdtd_stat_t stat,
  output fdtd_pkg::fdtd_cmd_t       cmd,
  output logic [CW-1:0]             m,
  output logic [CW-1:0]             n
);
  import fdtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WRITE, S_RD_ISSUE, S_RD_DATA, S_PASS,
    S_ISSUE, S_DIFF, S_MUL, S_WR, S_RESULT
  } state_t;

  state_t        state_r;
  pass_t         pass_r;
  logic [CW-1:0] m_r, n_r;
  logic          out_valid_r, err_r, from_read_r;

  logic [CW-1:0] sx, sy, sx1, sy1, m0, mlim, n0, nlim;
  logic [CW:0]   m_inc, n_inc;
  logic          empty, out_free;

  always_comb begin
    sx  = (CW'(size_x) > CW'(MAX_X)) ? CW'(MAX_X) : CW'(size_x);
    sy  = (CW'(size_y) > CW'(MAX_Y)) ? CW'(MAX_Y) : CW'(size_y);
    sx1 = (sx == '0) ? '0 : sx - 1'b1;
    sy1 = (sy == '0) ? '0 : sy - 1'b1;
    case (pass_r)
      P_HX: begin
        m0 = '0; mlim = sx; n0 = '0; nlim = sy1;
      end
      P_HY: begin
        m0 = '0; mlim = sx1; n0 = '0; nlim = one_d ? CW'(1) : sy;
      end
      default: begin
        m0 = CW'(1); mlim = sx1;
        n0 = one_d ? '0 : CW'(1);
        nlim = one_d ? CW'(1) : sy1;
      end
    endcase
    empty    = (m0 >= mlim) || (n0 >= nlim);
    m_inc    = {1'b0, m_r} + 1'b1;
    n_inc    = {1'b0, n_r} + 1'b1;
    out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    cmd = '0;
    cmd.kind          = pass_r;
    cmd.one_d         = one_d;
    cmd.capture       = (state_r == S_IDLE) && in_valid;
    cmd.use_cell      = (state_r == S_WRITE) || (state_r == S_RD_ISSUE) ||
                        (state_r == S_RD_DATA);
    cmd.cell_write    = (state_r == S_WRITE);
    cmd.rd_load       = (state_r == S_RD_DATA);
    cmd.diff_load     = (state_r == S_DIFF);
    cmd.mul_load      = (state_r == S_MUL);
    cmd.cell_we       = (state_r == S_WR);
    cmd.out_load      = (state_r == S_RESULT) && out_free;
    cmd.out_from_read = from_read_r;
    cmd.out_err       = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= P_HX;
      m_r         <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      from_read_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (stat.mode)
            MODE_WRITE: begin
              err_r       <= stat.bad;
              from_read_r <= 1'b0;
              state_r     <= stat.bad ? S_RESULT : S_WRITE;
            end
            MODE_READ: begin
              err_r       <= stat.bad;
              from_read_r <= !stat.bad;
              state_r     <= stat.bad ? S_RESULT : S_RD_ISSUE;
            end
            MODE_UPD_H: begin
              err_r       <= 1'b0;
              from_read_r <= 1'b0;
              pass_r      <= one_d ? P_HY : P_HX;
              state_r     <= S_PASS;
            end
            default: begin
              err_r       <= 1'b0;
              from_read_r <= 1'b0;
              pass_r      <= P_E;
              state_r     <= S_PASS;
            end
          endcase
        end
        S_WRITE:    state_r <= S_RESULT;
        S_RD_ISSUE: state_r <= S_RD_DATA;
        S_RD_DATA:  state_r <= S_RESULT;
        S_PASS: begin
          m_r <= m0;
          n_r <= n0;
          if (!empty) begin
            state_r <= S_ISSUE;
          end else if (pass_r == P_HX) begin
            pass_r <= P_HY;
          end else begin
            state_r <= S_RESULT;
          end
        end
        S_ISSUE: state_r <= S_DIFF;
        S_DIFF:  state_r <= S_MUL;
        S_MUL:   state_r <= S_WR;
        S_WR: begin
          if (n_inc < {1'b0, nlim}) begin
            n_r     <= n_inc[CW-1:0];
            state_r <= S_ISSUE;
          end else if (m_inc < {1'b0, mlim}) begin
            m_r     <= m_inc[CW-1:0];
            n_r     <= n0;
            state_r <= S_ISSUE;
          end else if (pass_r == P_HX) begin
            pass_r  <= P_HY;
            state_r <= S_PASS;
          end else begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign m         = m_r;
  assign n         = n_r;

  a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cell_we && cmd.cell_write))
    else $error("update write and cell write together");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");

  a_cell_coords_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE || state_r == S_DIFF || state_r == S_MUL) |=>
      ($stable(m_r) && $stable(n_r)))
    else $error("cell coordinates moved mid cell");

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ((int'(m_r) < MAX_X) && (int'(n_r) < MAX_Y)))
    else $error("cell outside grid");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result raised outside result state");

endmodule
`default_nettype wire

>>> rtl/fdtd_tmz_field_update.sv
// TMz FDTD field engine: Ez, Hx, Hy and six coefficient grids in block RAM.
// input channel (in_valid/in_ready): one command beat, mode selects
//   write cell, read cell, update H over the grid, update E over interior cells.
// result channel (out_valid/out_ready): one beat per command with read_value
//   (zero except for a good read) and status (1 for a bad cell or grid select).
// config channel (cfg_valid/cfg_ready, always ready): index 0 one_d_mode,
//   1 size_x_used, 2 size_y_used; other indexes are ignored. write only when idle.
// updates: each cell is read, differenced, multiplied and written back through
//   the single write port of each grid RAM before the next cell starts;
//   2D update H runs an Hx pass then an Hy pass.
// one command at a time; a new beat is taken while the previous result waits.
// if the receiver stalls, the finished result holds and the next command
//   waits in its last state until the output register frees.
// reset sets the config registers to 2D, 64 by 64 and clears control state;
//   grid contents are undefined until written, no clearing pass is run.
`default_nettype none
module fdtd_tmz_field_update #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [5:0]         in_cell_x,
  input  wire logic [5:0]         in_cell_y,
  input  wire logic [3:0]         in_grid_select,
  input  wire logic signed [31:0] in_write_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_read_value,
  output logic                    out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);
  import fdtd_pkg::*;

  localparam int MAXD = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int CWR  = $clog2(MAXD + 1);
  localparam int CW   = (CWR > 7) ? CWR : 7;

  logic          one_d_r;
  logic [6:0]    size_x_r, size_y_r;
  fdtd_cmd_t     cmd;
  fdtd_stat_t    stat;
  logic [CW-1:0] m, n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_d_r  <= 1'b0;
      size_x_r <= 7'd64;
      size_y_r <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ONE_D:  one_d_r  <= cfg_data[0];
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  fdtd_ctrl #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .one_d     (one_d_r),
    .size_x    (size_x_r),
    .size_y    (size_y_r),
    .stat      (stat),
    .cmd       (cmd),
    .m         (m),
    .n         (n)
  );

  fdtd_datapath #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .CW(CW)) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .m              (m),
    .n              (n),
    .in_mode        (in_mode),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_grid_select (in_grid_select),
    .in_write_value (in_write_value),
    .stat           (stat),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire
